[design/iq_dc_offset_tracker_top_defines.svh]
// assertion macros used by the dc offset tracker sequencer rtl
`ifndef IQ_DC_OFFSET_TRACKER_TOP_DEFINES_SVH
`define IQ_DC_OFFSET_TRACKER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define IQDC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define IQDC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/iqdc_pkg.sv]
// types and constants of the iq dc offset tracker
`timescale 1ns / 1ps

package iqdc_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int MAX_BLOCK   = 4096;
   localparam int LEN_W       = $clog2(MAX_BLOCK + 1);
   localparam int SUM_W       = SAMPLE_W + LEN_W;
   localparam int DIV_CNT_W   = $clog2(SUM_W);

   localparam int ALPHA_W     = 10;
   localparam int CAL_W       = 20;
   localparam int EMA_SCALE   = 1000;
   localparam int WEIGHT_W    = ALPHA_W + 1;
   localparam int PROD_W      = SAMPLE_W + WEIGHT_W;
   localparam int EMA_W       = PROD_W + 1;
   localparam int MAG_W       = EMA_W - 1;
   localparam int RECIP_SHIFT = 32;
   localparam longint RECIP   = (64'd1 << RECIP_SHIFT) / EMA_SCALE;
   localparam int RECIP_W     = RECIP_SHIFT - $clog2(EMA_SCALE) + 1;
   localparam int QUO_W       = MAG_W - $clog2(EMA_SCALE) + 1;

   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = CAL_W;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIB = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 2'd2;

   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 10'd100;
   localparam logic [CAL_W-1:0]   CALIB_RESET = 20'd1024;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_DIV_FIX,
      ST_EMA_MUL,
      ST_EMA_SUM,
      ST_EMA_RECIP,
      ST_EMA_FIX,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic             load;
      logic             block_mode;
      logic             close;
      logic             div_step;
      logic             div_fix;
      logic             ema_mul;
      logic             ema_sum;
      logic             ema_recip;
      logic             ema_fix;
      logic [LEN_W-1:0] div_len;
   } lane_ctrl_type;

endpackage

[design/iqdc_lane.sv]
// one channel lane: block accumulator, serial divider and ema update
`timescale 1ns / 1ps

module iqdc_lane (
   input  logic                                  clock,
   input  logic                                  reset,
   input  iqdc_pkg::lane_ctrl_type               ctrl,
   input  logic signed [iqdc_pkg::SAMPLE_W-1:0]  sample,
   input  logic        [iqdc_pkg::ALPHA_W-1:0]   weight,
   output logic signed [iqdc_pkg::SAMPLE_W-1:0]  corrected,
   output logic signed [iqdc_pkg::SAMPLE_W-1:0]  offset
);

   logic signed [iqdc_pkg::SAMPLE_W-1:0] offset_ff, offset_in;
   logic signed [iqdc_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic signed [iqdc_pkg::SAMPLE_W-1:0] corrected_ff, corrected_in;
   logic signed [iqdc_pkg::SAMPLE_W-1:0] x_ff, x_in;
   logic        [iqdc_pkg::SUM_W-1:0]    div_quo_ff, div_quo_in;
   logic        [iqdc_pkg::LEN_W-1:0]    div_rem_ff, div_rem_in;
   logic                                 div_neg_ff, div_neg_in;
   logic signed [iqdc_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [iqdc_pkg::EMA_W-1:0]    ema_ff, ema_in;
   logic        [iqdc_pkg::MAG_W-1:0]    mag_ff, mag_in;
   logic        [iqdc_pkg::QUO_W-1:0]    quo_ff, quo_in;
   logic                                 ema_neg_ff, ema_neg_in;

   logic signed [iqdc_pkg::SUM_W-1:0]      sum_next;
   logic        [iqdc_pkg::SUM_W-1:0]      sum_mag;
   logic        [iqdc_pkg::LEN_W:0]        rem_shift;
   logic        [iqdc_pkg::LEN_W:0]        rem_trial;
   logic                                   rem_fits;
   logic        [iqdc_pkg::SAMPLE_W:0]     avg_mag;
   logic        [iqdc_pkg::SAMPLE_W:0]     avg_val;
   logic signed [iqdc_pkg::PROD_W-1:0]     w_new, w_old, x_ext, old_ext;
   logic signed [iqdc_pkg::PROD_W-1:0]     old_prod;
   logic        [iqdc_pkg::EMA_W-1:0]      ema_abs;
   logic        [iqdc_pkg::MAG_W+iqdc_pkg::RECIP_W-1:0] recip_prod;
   logic        [iqdc_pkg::MAG_W:0]        back;
   logic        [iqdc_pkg::MAG_W:0]        rem_ema;
   logic        [iqdc_pkg::QUO_W-1:0]      quo_fix;
   logic        [iqdc_pkg::QUO_W:0]        res;

   always_comb begin
      // block accumulator and signed dividend
      sum_next = sum_ff + iqdc_pkg::SUM_W'(sample);
      sum_mag  = sum_next[iqdc_pkg::SUM_W-1] ? iqdc_pkg::SUM_W'(-sum_next)
                                             : iqdc_pkg::SUM_W'(sum_next);

      // restoring divider, one quotient bit a cycle
      rem_shift = {div_rem_ff, div_quo_ff[iqdc_pkg::SUM_W-1]};
      rem_fits  = rem_shift >= {1'b0, ctrl.div_len};
      rem_trial = rem_shift - {1'b0, ctrl.div_len};

      avg_mag = div_quo_ff[iqdc_pkg::SAMPLE_W:0];
      avg_val = div_neg_ff ? (~avg_mag + 1'b1) : avg_mag;

      // ema weights and products
      w_new    = iqdc_pkg::PROD_W'($signed({1'b0, weight}));
      w_old    = iqdc_pkg::PROD_W'(iqdc_pkg::EMA_SCALE) - w_new;
      x_ext    = iqdc_pkg::PROD_W'(x_ff);
      old_ext  = iqdc_pkg::PROD_W'(offset_ff);
      old_prod = w_old * old_ext;

      // divide by the scale through a reciprocal, then one correction step
      ema_abs    = ema_ff[iqdc_pkg::EMA_W-1] ? iqdc_pkg::EMA_W'(-ema_ff)
                                             : iqdc_pkg::EMA_W'(ema_ff);
      recip_prod = iqdc_pkg::MAG_W'(ema_abs)
                   * iqdc_pkg::RECIP_W'(iqdc_pkg::RECIP);
      back       = (iqdc_pkg::MAG_W+1)'(quo_ff) * (iqdc_pkg::MAG_W+1)'(iqdc_pkg::EMA_SCALE);
      rem_ema    = {1'b0, mag_ff} - back;
      quo_fix    = quo_ff + iqdc_pkg::QUO_W'(rem_ema >= (iqdc_pkg::MAG_W+1)'(iqdc_pkg::EMA_SCALE));
      res        = ema_neg_ff ? (~{1'b0, quo_fix} + 1'b1) : {1'b0, quo_fix};

      // next values
      offset_in    = offset_ff;
      sum_in       = sum_ff;
      corrected_in = corrected_ff;
      x_in         = x_ff;
      div_quo_in   = div_quo_ff;
      div_rem_in   = div_rem_ff;
      div_neg_in   = div_neg_ff;
      prod_in      = w_new * x_ext;
      ema_in       = iqdc_pkg::EMA_W'(prod_ff) + iqdc_pkg::EMA_W'(old_prod);
      mag_in       = iqdc_pkg::MAG_W'(ema_abs);
      quo_in       = iqdc_pkg::QUO_W'(recip_prod >> iqdc_pkg::RECIP_SHIFT);
      ema_neg_in   = ema_ff[iqdc_pkg::EMA_W-1];

      if (ctrl.load) begin
         corrected_in = sample - offset_ff;
         x_in         = sample;
         if (ctrl.block_mode && !ctrl.close) begin
            sum_in = sum_next;
         end else begin
            sum_in = '0;
         end
         div_quo_in = sum_mag;
         div_rem_in = '0;
         div_neg_in = sum_next[iqdc_pkg::SUM_W-1];
      end
      if (ctrl.div_step) begin
         div_quo_in = {div_quo_ff[iqdc_pkg::SUM_W-2:0], rem_fits};
         div_rem_in = rem_fits ? rem_trial[iqdc_pkg::LEN_W-1:0]
                               : rem_shift[iqdc_pkg::LEN_W-1:0];
      end
      if (ctrl.div_fix) begin
         x_in = avg_val[iqdc_pkg::SAMPLE_W-1:0];
      end
      if (ctrl.ema_fix) begin
         offset_in = res[iqdc_pkg::SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         sum_ff    <= '0;
      end else begin
         offset_ff <= offset_in;
         sum_ff    <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      corrected_ff <= corrected_in;
      x_ff         <= x_in;
      div_quo_ff   <= div_quo_in;
      div_rem_ff   <= div_rem_in;
      div_neg_ff   <= div_neg_in;
      if (ctrl.ema_mul) begin
         prod_ff <= prod_in;
      end
      if (ctrl.ema_sum) begin
         ema_ff <= ema_in;
      end
      if (ctrl.ema_recip) begin
         mag_ff     <= mag_in;
         quo_ff     <= quo_in;
         ema_neg_ff <= ema_neg_in;
      end
   end

   assign corrected = corrected_ff;
   assign offset    = offset_ff;

endmodule

[design/iqdc_ctrl.sv]
// sequencer, block length, sample counter and calibrated flag
`timescale 1ns / 1ps
`include "iq_dc_offset_tracker_top_defines.svh"

module iqdc_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_block_last,
   output logic                          req_ready,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   input  logic                          update_mode,
   input  logic [iqdc_pkg::CAL_W-1:0]    calibrate_after,
   output iqdc_pkg::lane_ctrl_type       lane_ctrl,
   output logic                          calibrated
);

   iqdc_pkg::state_type                state_ff, state_in;
   logic [iqdc_pkg::LEN_W-1:0]         len_ff, len_in;
   logic [iqdc_pkg::LEN_W-1:0]         div_len_ff, div_len_in;
   logic [iqdc_pkg::DIV_CNT_W-1:0]     div_cnt_ff, div_cnt_in;
   logic [iqdc_pkg::CAL_W-1:0]         count_ff, count_in;
   logic                               calibrated_ff, calibrated_in;

   logic                               accept;
   logic [iqdc_pkg::LEN_W-1:0]         len_inc;
   logic                               close;
   logic [iqdc_pkg::LEN_W-1:0]         add_n;
   logic [iqdc_pkg::CAL_W:0]           count_sum;
   logic [iqdc_pkg::CAL_W-1:0]         count_sat;
   logic                               count_upd;
   logic                               div_last;

   assign accept    = req_valid && req_ready;
   assign len_inc   = len_ff + 1'b1;
   assign close     = req_block_last || (len_inc >= iqdc_pkg::LEN_W'(iqdc_pkg::MAX_BLOCK));
   assign add_n     = update_mode ? len_inc : iqdc_pkg::LEN_W'(1);
   assign count_sum = {1'b0, count_ff} + (iqdc_pkg::CAL_W+1)'(add_n);
   assign count_sat = count_sum[iqdc_pkg::CAL_W] ? '1 : count_sum[iqdc_pkg::CAL_W-1:0];
   assign count_upd = accept && (!update_mode || close);
   assign div_last  = div_cnt_ff == iqdc_pkg::DIV_CNT_W'(iqdc_pkg::SUM_W - 1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         iqdc_pkg::ST_IDLE: begin
            if (accept) begin
               if (!update_mode) begin
                  state_in = iqdc_pkg::ST_EMA_MUL;
               end else if (close) begin
                  state_in = iqdc_pkg::ST_DIVIDE;
               end else begin
                  state_in = iqdc_pkg::ST_RESPOND;
               end
            end
         end
         iqdc_pkg::ST_DIVIDE: begin
            if (div_last) begin
               state_in = iqdc_pkg::ST_DIV_FIX;
            end
         end
         iqdc_pkg::ST_DIV_FIX:   state_in = iqdc_pkg::ST_EMA_MUL;
         iqdc_pkg::ST_EMA_MUL:   state_in = iqdc_pkg::ST_EMA_SUM;
         iqdc_pkg::ST_EMA_SUM:   state_in = iqdc_pkg::ST_EMA_RECIP;
         iqdc_pkg::ST_EMA_RECIP: state_in = iqdc_pkg::ST_EMA_FIX;
         iqdc_pkg::ST_EMA_FIX:   state_in = iqdc_pkg::ST_RESPOND;
         iqdc_pkg::ST_RESPOND: begin
            if (rsp_ready) begin
               state_in = iqdc_pkg::ST_IDLE;
            end
         end
         default: state_in = iqdc_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready            = 1'b0;
      rsp_valid            = 1'b0;
      lane_ctrl            = '0;
      lane_ctrl.div_len    = div_len_ff;
      lane_ctrl.block_mode = update_mode;
      lane_ctrl.close      = close;
      case (state_ff)
         iqdc_pkg::ST_IDLE: begin
            // nothing is taken while reset is held
            req_ready      = !reset;
            lane_ctrl.load = req_valid && !reset;
         end
         iqdc_pkg::ST_DIVIDE:    lane_ctrl.div_step  = 1'b1;
         iqdc_pkg::ST_DIV_FIX:   lane_ctrl.div_fix   = 1'b1;
         iqdc_pkg::ST_EMA_MUL:   lane_ctrl.ema_mul   = 1'b1;
         iqdc_pkg::ST_EMA_SUM:   lane_ctrl.ema_sum   = 1'b1;
         iqdc_pkg::ST_EMA_RECIP: lane_ctrl.ema_recip = 1'b1;
         iqdc_pkg::ST_EMA_FIX:   lane_ctrl.ema_fix   = 1'b1;
         iqdc_pkg::ST_RESPOND:   rsp_valid           = 1'b1;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      len_in        = len_ff;
      div_len_in    = div_len_ff;
      div_cnt_in    = div_cnt_ff;
      count_in      = count_ff;
      calibrated_in = calibrated_ff;
      if (accept) begin
         div_len_in = len_inc;
         div_cnt_in = '0;
         len_in     = (update_mode && !close) ? len_inc : '0;
      end
      if (state_ff == iqdc_pkg::ST_DIVIDE) begin
         div_cnt_in = div_cnt_ff + 1'b1;
      end
      if (count_upd) begin
         count_in = count_sat;
         if (count_sat >= calibrate_after) begin
            calibrated_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= iqdc_pkg::ST_IDLE;
         len_ff        <= '0;
         div_cnt_ff    <= '0;
         count_ff      <= '0;
         calibrated_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         len_ff        <= len_in;
         div_cnt_ff    <= div_cnt_in;
         count_ff      <= count_in;
         calibrated_ff <= calibrated_in;
      end
   end

   always_ff @(posedge clock) begin
      div_len_ff <= div_len_in;
   end

   assign calibrated = calibrated_ff;

   `IQDC_ASSERT_NOW(a_div_len_nonzero, clock, reset, state_ff == iqdc_pkg::ST_DIVIDE, div_len_ff != '0, "divider started with zero block length")
   `IQDC_ASSERT_NEXT(a_calib_sticky, clock, reset, calibrated_ff, calibrated_ff, "calibrated flag dropped")
   `IQDC_ASSERT_NEXT(a_count_monotonic, clock, reset, 1'b1, count_ff >= $past(count_ff), "sample counter went backward")
   `IQDC_ASSERT_NEXT(a_fix_then_respond, clock, reset, state_ff == iqdc_pkg::ST_EMA_FIX, rsp_valid, "ema result not presented after update")

endmodule

[design/iq_dc_offset_tracker_top.sv]
// top level of the iq dc offset tracker
//
//   channel   ports                                          direction
//   req       req_valid/req_ready, sample_i/q, block_last     in
//   rsp       rsp_valid/rsp_ready, clean i/q, dc i/q, flag    out
//   csr       csr_valid/csr_ready, csr_index, csr_data        in
//
// per-sample mode: a transaction is accept, four ema steps, then the response
// block mode: accept, response in a block; a close adds divide, fix, ema steps
// the block average goes through a one-bit-a-cycle divider in each lane
// reset is synchronous and clears offsets, accumulators, counter and flag
// a stalled response holds the block; no new request is taken until it leaves
`timescale 1ns / 1ps

module iq_dc_offset_tracker_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [iqdc_pkg::SAMPLE_W-1:0]    req_sample_i,
   input  logic signed [iqdc_pkg::SAMPLE_W-1:0]    req_sample_q,
   input  logic                                    req_block_last,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [iqdc_pkg::SAMPLE_W-1:0]    rsp_clean_i,
   output logic signed [iqdc_pkg::SAMPLE_W-1:0]    rsp_clean_q,
   output logic signed [iqdc_pkg::SAMPLE_W-1:0]    rsp_dc_i,
   output logic signed [iqdc_pkg::SAMPLE_W-1:0]    rsp_dc_q,
   output logic                                    rsp_calibrated,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic        [iqdc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic        [iqdc_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic [iqdc_pkg::ALPHA_W-1:0] alpha_ff, alpha_in;
   logic [iqdc_pkg::CAL_W-1:0]   calib_ff, calib_in;
   logic                         mode_ff, mode_in;
   logic [iqdc_pkg::ALPHA_W-1:0] weight;
   iqdc_pkg::lane_ctrl_type      lane_ctrl;

   assign csr_ready = !reset;

   always_comb begin
      alpha_in = alpha_ff;
      calib_in = calib_ff;
      mode_in  = mode_ff;
      if (csr_valid) begin
         case (csr_index)
            iqdc_pkg::CSR_ALPHA: alpha_in = csr_data[iqdc_pkg::ALPHA_W-1:0];
            iqdc_pkg::CSR_CALIB: calib_in = csr_data[iqdc_pkg::CAL_W-1:0];
            iqdc_pkg::CSR_MODE:  mode_in  = csr_data[0];
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= iqdc_pkg::ALPHA_RESET;
         calib_ff <= iqdc_pkg::CALIB_RESET;
         mode_ff  <= 1'b0;
      end else begin
         alpha_ff <= alpha_in;
         calib_ff <= calib_in;
         mode_ff  <= mode_in;
      end
   end

   // weight saturates at full scale
   assign weight = (alpha_ff > iqdc_pkg::ALPHA_W'(iqdc_pkg::EMA_SCALE))
                   ? iqdc_pkg::ALPHA_W'(iqdc_pkg::EMA_SCALE) : alpha_ff;

   iqdc_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_block_last  (req_block_last),
      .req_ready       (req_ready),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .update_mode     (mode_ff),
      .calibrate_after (calib_ff),
      .lane_ctrl       (lane_ctrl),
      .calibrated      (rsp_calibrated)
   );

   iqdc_lane u_lane_i (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (lane_ctrl),
      .sample    (req_sample_i),
      .weight    (weight),
      .corrected (rsp_clean_i),
      .offset    (rsp_dc_i)
   );

   iqdc_lane u_lane_q (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (lane_ctrl),
      .sample    (req_sample_q),
      .weight    (weight),
      .corrected (rsp_clean_q),
      .offset    (rsp_dc_q)
   );

endmodule

[verif/tb_iq_dc_offset_tracker_top.sv]
// self-checking testbench for the iq dc offset tracker with a built-in offset predictor
`timescale 1ns / 1ps

module tb_iq_dc_offset_tracker_top;

   localparam logic [iqdc_pkg::CSR_IDX_W-1:0] CSR_SPARE   = 2'd3;
   localparam logic                           MODE_SAMPLE = 1'b0;
   localparam logic                           MODE_BLOCK  = 1'b1;
   localparam int                             COUNT_MAX   = (1 << iqdc_pkg::CAL_W) - 1;
   localparam int                             QUIET_LIMIT = 2000;

   typedef logic signed [iqdc_pkg::SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      sample_type clean_i;
      sample_type clean_q;
      sample_type dc_i;
      sample_type dc_q;
      logic       calibrated;
   } report_type;

   typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_type;

   typedef struct packed {
      row_kind_type                        kind;
      logic [iqdc_pkg::CSR_IDX_W-1:0]      csr_idx;
      logic [iqdc_pkg::CSR_DATA_W-1:0]     csr_val;
      sample_type                          si;
      sample_type                          sq;
      logic                                last;
      logic                                typed;
      report_type                          want;
   } plan_row_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_PERIODIC,
      READY_MOSTLY
   } ready_style_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   sample_type                      req_sample_i = '0;
   sample_type                      req_sample_q = '0;
   logic                            req_block_last = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   sample_type                      rsp_clean_i;
   sample_type                      rsp_clean_q;
   sample_type                      rsp_dc_i;
   sample_type                      rsp_dc_q;
   logic                            rsp_calibrated;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [iqdc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [iqdc_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // typed expectation travels with the transaction like payload
   logic                            row_typed = 1'b0;
   report_type                      row_want = '0;

   // predictor state and configuration
   logic [iqdc_pkg::ALPHA_W-1:0]    cfg_alpha;
   logic [iqdc_pkg::CAL_W-1:0]      cfg_calib;
   logic                            cfg_mode;
   sample_type                      track_i;
   sample_type                      track_q;
   int                              track_count;
   logic                            track_cal;
   longint                          acc_i;
   longint                          acc_q;
   int                              acc_len;

   report_type                      pending_reports[$];
   plan_row_type                    directed_plan[$];
   int                              mismatches = 0;
   int                              quiet_cycles = 0;
   int                              burst_left = 0;

   ready_style_type                 stall_style = READY_ALWAYS;
   int                              stall_left = 0;
   int                              stall_period = 4;
   int                              stall_tick = 0;

   iq_dc_offset_tracker_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_i    (req_sample_i),
      .req_sample_q    (req_sample_q),
      .req_block_last  (req_block_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_clean_i     (rsp_clean_i),
      .rsp_clean_q     (rsp_clean_q),
      .rsp_dc_i        (rsp_dc_i),
      .rsp_dc_q        (rsp_dc_q),
      .rsp_calibrated  (rsp_calibrated),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic sample_type ema_step(input longint prev, input longint x);
      longint w;
      w = (cfg_alpha > iqdc_pkg::EMA_SCALE) ? iqdc_pkg::EMA_SCALE : cfg_alpha;
      return sample_type'((w * x + (iqdc_pkg::EMA_SCALE - w) * prev) / iqdc_pkg::EMA_SCALE);
   endfunction

   function automatic void count_samples(input int n);
      longint c;
      c = longint'(track_count) + n;
      track_count = (c > COUNT_MAX) ? COUNT_MAX : int'(c);
      if (track_count >= cfg_calib) begin
         track_cal = 1'b1;
      end
   endfunction

   function automatic report_type track_offset(input sample_type si, input sample_type sq,
                                               input logic last);
      report_type r;
      longint avg_i;
      longint avg_q;
      r.clean_i = si - track_i;
      r.clean_q = sq - track_q;
      if (cfg_mode == MODE_SAMPLE) begin
         track_i = ema_step(track_i, si);
         track_q = ema_step(track_q, sq);
         acc_i = 0;
         acc_q = 0;
         acc_len = 0;
         count_samples(1);
      end else begin
         acc_i += si;
         acc_q += sq;
         acc_len++;
         // a block also closes on its own once it is full
         if (last || acc_len >= iqdc_pkg::MAX_BLOCK) begin
            avg_i = acc_i / longint'(acc_len);
            avg_q = acc_q / longint'(acc_len);
            track_i = ema_step(track_i, avg_i);
            track_q = ema_step(track_q, avg_q);
            count_samples(acc_len);
            acc_i = 0;
            acc_q = 0;
            acc_len = 0;
         end
      end
      r.dc_i = track_i;
      r.dc_q = track_q;
      r.calibrated = track_cal;
      return r;
   endfunction

   function automatic void check_report(input report_type want);
      if (rsp_clean_i !== want.clean_i) begin
         $error("clean_i: expected %0d, got %0d", want.clean_i, rsp_clean_i);
         mismatches++;
      end
      if (rsp_clean_q !== want.clean_q) begin
         $error("clean_q: expected %0d, got %0d", want.clean_q, rsp_clean_q);
         mismatches++;
      end
      if (rsp_dc_i !== want.dc_i) begin
         $error("dc_i: expected %0d, got %0d", want.dc_i, rsp_dc_i);
         mismatches++;
      end
      if (rsp_dc_q !== want.dc_q) begin
         $error("dc_q: expected %0d, got %0d", want.dc_q, rsp_dc_q);
         mismatches++;
      end
      if (rsp_calibrated !== want.calibrated) begin
         $error("calibrated: expected %0d, got %0d", want.calibrated, rsp_calibrated);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : scoreboard
      report_type model_out;
      if (reset) begin
         cfg_alpha = iqdc_pkg::ALPHA_RESET;
         cfg_calib = iqdc_pkg::CALIB_RESET;
         cfg_mode = MODE_SAMPLE;
         track_i = '0;
         track_q = '0;
         track_count = 0;
         track_cal = 1'b0;
         acc_i = 0;
         acc_q = 0;
         acc_len = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               iqdc_pkg::CSR_ALPHA: cfg_alpha = csr_data[iqdc_pkg::ALPHA_W-1:0];
               iqdc_pkg::CSR_CALIB: cfg_calib = csr_data[iqdc_pkg::CAL_W-1:0];
               iqdc_pkg::CSR_MODE:  cfg_mode = csr_data[0];
               default:             ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_reports.size() == 0) begin
               $error("response transaction with no sample pending");
               mismatches++;
            end else begin
               check_report(pending_reports.pop_front());
            end
         end
         if (req_valid && req_ready) begin
            model_out = track_offset(req_sample_i, req_sample_q, req_block_last);
            if (row_typed) begin
               model_out = row_want;
            end
            pending_reports.push_back(model_out);
         end
      end
   end

   // ---------------------------------------------------------------- receiver and watchdog

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style <= ready_style_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(30, 200);
         stall_period <= $urandom_range(2, 9);
      end else begin
         stall_left <= stall_left - 1;
      end
      stall_tick <= (stall_tick + 1 >= stall_period) ? 0 : stall_tick + 1;
      case (stall_style)
         READY_ALWAYS:   rsp_ready <= 1'b1;
         READY_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
         READY_PERIODIC: rsp_ready <= (stall_tick == 0);
         READY_MOSTLY:   rsp_ready <= ($urandom_range(0, 15) != 0);
         default:        rsp_ready <= 1'b1;
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- drivers

   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic send_item(input sample_type si, input sample_type sq, input logic last,
                            input logic typed, input report_type want);
      pace();
      req_valid <= 1'b1;
      req_sample_i <= si;
      req_sample_q <= sq;
      req_block_last <= last;
      row_typed <= typed;
      row_want <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [iqdc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [iqdc_pkg::CSR_DATA_W-1:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic sample_type pick_sample(input int bias);
      case ($urandom_range(0, 9))
         0:       return sample_type'(-32768);
         1:       return sample_type'(32767);
         2, 3, 4: return sample_type'(bias + int'($urandom_range(0, 64)) - 32);
         default: return sample_type'($urandom);
      endcase
   endfunction

   // one setting of the registers, then a run of random transactions
   task automatic run_phase(input logic mode, input int alpha_v, input int cal_v,
                            input int count, input int max_len);
      logic [iqdc_pkg::CSR_DATA_W-1:0] junk;
      int bias_i;
      int bias_q;
      int left;
      logic last;
      junk = iqdc_pkg::CSR_DATA_W'($urandom);
      bias_i = int'($urandom_range(0, 60000)) - 30000;
      bias_q = int'($urandom_range(0, 60000)) - 30000;
      left = 0;
      write_csr(iqdc_pkg::CSR_ALPHA,
                {junk[iqdc_pkg::CSR_DATA_W-1:iqdc_pkg::ALPHA_W],
                 alpha_v[iqdc_pkg::ALPHA_W-1:0]});
      write_csr(iqdc_pkg::CSR_CALIB, cal_v[iqdc_pkg::CAL_W-1:0]);
      write_csr(iqdc_pkg::CSR_MODE, {junk[iqdc_pkg::CSR_DATA_W-1:1], mode});
      write_csr(CSR_SPARE, iqdc_pkg::CSR_DATA_W'($urandom));
      for (int n = 0; n < count; n++) begin
         if (mode == MODE_BLOCK) begin
            if (left == 0) begin
               left = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 300)
                                                   : $urandom_range(1, max_len);
            end
            left--;
            // now and then a block is cut short
            if ($urandom_range(0, 49) == 0) begin
               left = 0;
            end
            last = (left == 0);
         end else begin
            last = 1'($urandom_range(0, 1));
         end
         send_item(pick_sample(bias_i), pick_sample(bias_q), last, 1'b0, '0);
      end
   endtask

   function automatic plan_row_type write_row(input logic [iqdc_pkg::CSR_IDX_W-1:0] idx,
                                              input int val);
      plan_row_type r;
      r = '0;
      r.kind = ROW_WRITE;
      r.csr_idx = idx;
      r.csr_val = val[iqdc_pkg::CSR_DATA_W-1:0];
      return r;
   endfunction

   function automatic plan_row_type sample_row(input int si, input int sq, input logic last);
      plan_row_type r;
      r = '0;
      r.kind = ROW_SAMPLE;
      r.si = sample_type'(si);
      r.sq = sample_type'(sq);
      r.last = last;
      return r;
   endfunction

   function automatic plan_row_type known_row(input int si, input int sq, input logic last,
                                              input int ci, input int cq, input int oi,
                                              input int oq, input logic cal);
      plan_row_type r;
      r = sample_row(si, sq, last);
      r.typed = 1'b1;
      r.want.clean_i = sample_type'(ci);
      r.want.clean_q = sample_type'(cq);
      r.want.dc_i = sample_type'(oi);
      r.want.dc_q = sample_type'(oq);
      r.want.calibrated = cal;
      return r;
   endfunction

   initial begin
      // offsets start at zero after reset
      directed_plan.push_back(known_row(32767, -32768, 1'b0, 32767, -32768, 3276, -3276, 1'b0));
      // block_last has no effect in per-sample mode
      directed_plan.push_back(sample_row(-32768, 32767, 1'b1));
      directed_plan.push_back(sample_row(0, 0, 1'b0));
      directed_plan.push_back(sample_row(-1, 1, 1'b0));
      // full weight: offset follows the sample
      directed_plan.push_back(write_row(iqdc_pkg::CSR_ALPHA, 1000));
      directed_plan.push_back(sample_row(12345, -12345, 1'b0));
      directed_plan.push_back(known_row(-32768, 32767, 1'b0, 20423, -20424, -32768, 32767,
                                        1'b0));
      // zero weight: offset held, corrected wraps
      directed_plan.push_back(write_row(iqdc_pkg::CSR_ALPHA, 0));
      directed_plan.push_back(known_row(32767, 32767, 1'b0, -1, 0, -32768, 32767, 1'b0));
      // weight above 1000 saturates
      directed_plan.push_back(write_row(iqdc_pkg::CSR_ALPHA, 1023));
      directed_plan.push_back(known_row(100, -100, 1'b0, -32668, 32669, 100, -100, 1'b0));
      directed_plan.push_back(write_row(iqdc_pkg::CSR_ALPHA, 500));
      directed_plan.push_back(write_row(iqdc_pkg::CSR_MODE, MODE_BLOCK));
      // inside a block the offsets hold
      directed_plan.push_back(known_row(1001, -1001, 1'b0, 901, -901, 100, -100, 1'b0));
      directed_plan.push_back(sample_row(-3, 4, 1'b0));
      directed_plan.push_back(sample_row(0, 0, 1'b1));
      directed_plan.push_back(sample_row(32767, -32768, 1'b1));
      // block average truncates toward zero
      directed_plan.push_back(sample_row(-3, 3, 1'b0));
      directed_plan.push_back(sample_row(0, -2, 1'b1));
      // partial block dropped on the switch back to per-sample mode
      directed_plan.push_back(sample_row(1000, 1000, 1'b0));
      directed_plan.push_back(write_row(iqdc_pkg::CSR_MODE, MODE_SAMPLE));
      directed_plan.push_back(sample_row(0, 0, 1'b1));
      directed_plan.push_back(write_row(iqdc_pkg::CSR_CALIB, COUNT_MAX));
      directed_plan.push_back(sample_row(-7, 7, 1'b0));
      // zero threshold: flag rises only when the block closes
      directed_plan.push_back(write_row(iqdc_pkg::CSR_CALIB, 0));
      directed_plan.push_back(write_row(iqdc_pkg::CSR_MODE, MODE_BLOCK));
      directed_plan.push_back(sample_row(5, 5, 1'b0));
      directed_plan.push_back(sample_row(-5, -5, 1'b1));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[n]) begin
         if (directed_plan[n].kind == ROW_WRITE) begin
            write_csr(directed_plan[n].csr_idx, directed_plan[n].csr_val);
         end else begin
            send_item(directed_plan[n].si, directed_plan[n].sq, directed_plan[n].last,
                      directed_plan[n].typed, directed_plan[n].want);
         end
      end

      run_phase(MODE_SAMPLE, $urandom_range(0, 1023), COUNT_MAX, 250, 1);
      run_phase(MODE_BLOCK, 1000, $urandom_range(0, COUNT_MAX), 250, 8);
      run_phase(MODE_BLOCK, $urandom_range(1, 999), 0, 250, 40);
      run_phase(MODE_SAMPLE, 0, $urandom_range(0, COUNT_MAX), 200, 1);
      run_phase(MODE_BLOCK, 1023, $urandom_range(0, COUNT_MAX), 250, 16);
      run_phase(MODE_SAMPLE, 1, $urandom_range(0, COUNT_MAX), 250, 1);

      drain();
      repeat (60) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
